// ----- src/qht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QoS handshake tracker package
// Shared constants, operation and status codes, handshake phases and the
// sequencer states of the in-flight handshake tracker.
// ----------------------------------------------------------------------------
package qht_pkg;

  // Default number of table entries.
  localparam int unsigned TableDepthDef = 64;

  // Field widths of one table word.
  localparam int unsigned IdW    = 16;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned WordW  = IdW + PhaseW;

  // Operation codes carried on mode_i.
  typedef enum logic [3:0] {
    ModeTrackOut = 4'd0,
    ModeTrackIn  = 4'd1,
    ModePuback   = 4'd2,
    ModePubrec   = 4'd3,
    ModePubrel   = 4'd4,
    ModePubcomp  = 4'd5,
    ModeNext     = 4'd6,
    ModeRemove   = 4'd7,
    ModeQuery    = 4'd8
  } mode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatPending  = 3'd1,
    StatFull     = 3'd2,
    StatNotFound = 3'd3,
    StatWrong    = 3'd4,
    StatNoAction = 3'd5
  } status_e;

  // Handshake phase stored with each entry.
  typedef enum logic [PhaseW-1:0] {
    PhWaitPuback  = 3'd0,
    PhWaitPubrec  = 3'd1,
    PhWaitPubrel  = 3'd2,
    PhWaitPubcomp = 3'd3,
    PhComplete    = 3'd4
  } phase_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StRemRd,
    StRemWr,
    StDone
  } state_e;

endpackage

// ----- src/qos_handshake_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QoS handshake tracker
// Table of in-flight QoS 1 and QoS 2 handshakes, each entry a packet id and
// a handshake phase, held in one synchronous RAM and scanned word by word.
// ----------------------------------------------------------------------------
// Track words and unknown codes go straight to the result; lookups scan the
// table entry by entry, as the table RAM returns one registered word a cycle,
// and a remove then reads the last entry and writes it into the freed slot.
// The unit takes one word at a time; busy_o stays high through the result
// strobe and the next word is taken in the cycle after it at the earliest. No stalls.
// Reset: asynchronous, active low; it clears the entry count but not the RAM.
// ----------------------------------------------------------------------------
module qos_handshake_tracker_unit
  import qht_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [3:0]      mode_i,
  input  logic [IdW-1:0]  pkt_id_i,
  input  logic [1:0]      qos_i,
  output logic            result_valid_o,
  output logic [2:0]      status_o,
  output logic [IdW-1:0]  action_id_o,
  output logic            send_kind_o,
  output logic            complete_o
);

  // The count must be able to hold the depth itself; RAM addresses only
  // need to reach the last entry.
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  // Sequencer and operation registers.
  state_e           state_q, state_d;
  logic [3:0]       mode_q, mode_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // Scan pointers: idx_q is the next entry to read, chk_idx_q the entry whose
  // word arrives from the RAM in this cycle when chk_vld_q is set.
  logic [CntW-1:0]  idx_q, idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [AddrW-1:0] chk_idx_q, chk_idx_d;
  logic [AddrW-1:0] hit_idx_q, hit_idx_d;

  // Result registers.
  logic [2:0]       status_q, status_d;
  logic [IdW-1:0]   act_q, act_d;
  logic             kind_q, kind_d;
  logic             done_q, done_d;

  // RAM port signals.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [WordW-1:0] ram_rdata;

  qht_ram #(
    .Width (WordW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Decoding of the word returned by the RAM.
  logic [IdW-1:0]  rd_id;
  phase_e          rd_phase;
  logic            unfinished;
  logic            match;
  logic            hit;
  logic            more;
  logic            accept;
  logic            is_track;
  logic [CntW-1:0] last_idx;
  phase_e          expect_ph;
  phase_e          next_ph;
  phase_e          new_ph;

  assign rd_id      = ram_rdata[WordW-1:PhaseW];
  assign rd_phase   = phase_e'(ram_rdata[PhaseW-1:0]);
  assign unfinished = rd_phase inside {PhWaitPuback, PhWaitPubrec, PhWaitPubrel,
                                       PhWaitPubcomp};
  // Next action looks for the first unfinished entry; every other lookup
  // looks for the first entry carrying the requested id.
  assign match      = (mode_q == ModeNext) ? unfinished : (rd_id == id_q);
  assign hit        = chk_vld_q && match;
  assign more       = (idx_q < cnt_q);
  assign accept     = start_i && (state_q == StIdle);
  assign is_track   = (mode_i == ModeTrackOut) || (mode_i == ModeTrackIn);
  assign last_idx   = cnt_q - CntW'(1);

  // Expected and following phase for each acknowledgment.
  always_comb begin
    expect_ph = PhWaitPuback;
    next_ph   = PhComplete;
    case (mode_q)
      ModePuback: begin
        expect_ph = PhWaitPuback;
        next_ph   = PhComplete;
      end
      ModePubrec: begin
        expect_ph = PhWaitPubrec;
        next_ph   = PhWaitPubcomp;
      end
      ModePubrel: begin
        expect_ph = PhWaitPubrel;
        next_ph   = PhComplete;
      end
      ModePubcomp: begin
        expect_ph = PhWaitPubcomp;
        next_ph   = PhComplete;
      end
      default: begin
        expect_ph = PhWaitPuback;
        next_ph   = PhComplete;
      end
    endcase
  end

  // Phase of a newly tracked entry; a QoS of three counts as QoS 2.
  always_comb begin
    if (mode_i == ModeTrackOut) begin
      new_ph = (qos_i == 2'd1) ? PhWaitPuback : PhWaitPubrec;
    end else begin
      new_ph = (qos_i == 2'd1) ? PhComplete : PhWaitPubrel;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (is_track || !(mode_i inside {[ModePuback:ModeQuery]})) begin
            state_d = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (hit) begin
          state_d = (mode_q == ModeRemove) ? StRemRd : StDone;
        end else if (!more && !chk_vld_q) begin
          state_d = StDone;
        end
      end
      StRemRd: state_d = StRemWr;
      StRemWr: state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath, RAM control and result logic.
  always_comb begin
    mode_d    = mode_q;
    id_d      = id_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    hit_idx_d = hit_idx_q;
    status_d  = status_q;
    act_d     = act_q;
    kind_d    = kind_q;
    done_d    = done_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AddrW-1:0];
    ram_wdata = {pkt_id_i, new_ph};
    ram_re    = 1'b0;
    ram_raddr = idx_q[AddrW-1:0];

    case (state_q)
      StIdle: begin
        if (accept) begin
          mode_d   = mode_i;
          id_d     = pkt_id_i;
          idx_d    = '0;
          act_d    = '0;
          kind_d   = 1'b0;
          done_d   = 1'b0;
          status_d = StatNoAction;
          if (is_track) begin
            if (qos_i == 2'd0) begin
              // QoS 0 needs no handshake and is not stored.
              status_d = StatOk;
            end else if (cnt_q == CntW'(TableDepth)) begin
              status_d = StatFull;
            end else begin
              ram_we   = 1'b1;
              cnt_d    = cnt_q + CntW'(1);
              status_d = StatOk;
            end
          end
        end
      end

      StScan: begin
        if (hit) begin
          case (mode_q)
            ModeNext: begin
              act_d    = rd_id;
              kind_d   = !(rd_phase inside {PhWaitPuback, PhWaitPubrec});
              status_d = (rd_phase == PhWaitPubrel) ? StatPending : StatOk;
            end
            ModeQuery: begin
              status_d = StatOk;
              done_d   = (rd_phase == PhComplete);
            end
            ModeRemove: begin
              hit_idx_d = chk_idx_q;
            end
            default: begin
              // Acknowledgment: advance only from the expected phase.
              if (rd_phase == expect_ph) begin
                ram_we    = 1'b1;
                ram_waddr = chk_idx_q;
                ram_wdata = {id_q, next_ph};
                status_d  = StatOk;
              end else begin
                status_d  = StatWrong;
              end
            end
          endcase
        end else if (more) begin
          ram_re    = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q[AddrW-1:0];
          idx_d     = idx_q + CntW'(1);
        end else if (!chk_vld_q) begin
          status_d = (mode_q == ModeNext) ? StatNoAction : StatNotFound;
        end
      end

      StRemRd: begin
        // Fetch the last entry so that it can fill the freed slot.
        ram_re    = 1'b1;
        ram_raddr = last_idx[AddrW-1:0];
      end

      StRemWr: begin
        // When the freed slot is the last one this rewrites it unchanged.
        ram_we    = 1'b1;
        ram_waddr = hit_idx_q;
        ram_wdata = ram_rdata;
        cnt_d     = last_idx;
        status_d  = StatOk;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    id_q      <= id_d;
    idx_q     <= idx_d;
    chk_idx_q <= chk_idx_d;
    hit_idx_q <= hit_idx_d;
    status_q  <= status_d;
    act_q     <= act_d;
    kind_q    <= kind_d;
    done_q    <= done_d;
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = (state_q == StDone);
  assign status_o       = status_q;
  assign action_id_o    = act_q;
  assign send_kind_o    = kind_q;
  assign complete_o     = done_q;

endmodule

// ----- src/qht_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port synchronous RAM: one write port and one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module qht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/qht_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QoS handshake tracker checker
// Port-level properties of the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module qht_checker
  import qht_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           result_valid_o,
  input logic [2:0]     status_o,
  input logic [IdW-1:0] action_id_o,
  input logic           send_kind_o,
  input logic           complete_o
);

  // An accepted word keeps the unit busy until its result.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("unit not busy after accepting a word");

  // A result only appears while an operation is in flight.
  a_result_in_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe outside an operation");

  // Exactly one result per operation, after which the unit is free again.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy_o)
    else $error("result strobe not followed by idle");

  // Only a successful or pending next action names a packet id.
  a_action_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != StatOk) && (status_o != StatPending)
      |-> (action_id_o == '0) && !send_kind_o && !complete_o)
    else $error("payload set on a failed operation");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o <= StatNoAction)
    else $error("undefined status code");

endmodule

bind qos_handshake_tracker_unit qht_checker u_qht_checker (.*);
